/* rtl/aesf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aesf_pkg
// Shared types, codes and constants of the escape filter with style tracking.
// ----------------------------------------------------------------------------
package aesf_pkg;

    // Display actions
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_PRINT = 3'd1;
    localparam logic [2:0] ACT_LF    = 3'd2;
    localparam logic [2:0] ACT_CR    = 3'd3;
    localparam logic [2:0] ACT_BS    = 3'd4;

    // Colour kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_DEFAULT = 2'd1;
    localparam logic [1:0] KIND_PALETTE = 2'd2;
    localparam logic [1:0] KIND_RGB     = 2'd3;

    // Extended colour phases
    localparam logic [2:0] XP_NONE  = 3'd0;
    localparam logic [2:0] XP_MODE  = 3'd1;
    localparam logic [2:0] XP_INDEX = 3'd2;
    localparam logic [2:0] XP_RED   = 3'd3;
    localparam logic [2:0] XP_GREEN = 3'd4;
    localparam logic [2:0] XP_BLUE  = 3'd5;

    // Bytes of interest
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_FIN_LO = 8'h40;
    localparam logic [7:0] CH_FIN_HI = 8'h7e;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_M      = 8'h6d;

    typedef struct packed {
        logic        bold;
        logic        italic;
        logic        underline;
        logic        reverse;
        logic        fg_def;
        logic        bg_def;
        logic [1:0]  fg_kind;
        logic [1:0]  bg_kind;
        logic [23:0] fg_value;
        logic [23:0] bg_value;
    } t_style;

    typedef struct packed {
        t_style      work;
        logic [2:0]  phase;
        logic        is_fg;
        logic [7:0]  red;
        logic [7:0]  green;
    } t_sgr;

    function automatic t_style style_clear();
        t_style s;
        s           = '0;
        s.fg_def    = 1'b1;
        s.bg_def    = 1'b1;
        s.fg_kind   = KIND_PALETTE;
        s.bg_kind   = KIND_PALETTE;
        return s;
    endfunction

endpackage
`default_nettype wire

/* rtl/aesf_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aesf_in_if
// Input channel: one raw terminal byte per beat.
// ----------------------------------------------------------------------------
interface aesf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

/* rtl/aesf_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aesf_out_if
// Result channel: display action and live style per beat.
// ----------------------------------------------------------------------------
interface aesf_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  char_out;
    logic        bold;
    logic        italic;
    logic        underline;
    logic [1:0]  fg_kind;
    logic [23:0] fg_value;
    logic [1:0]  bg_kind;
    logic [23:0] bg_value;

    modport source (output valid, output action, output char_out, output bold,
                    output italic, output underline, output fg_kind, output fg_value,
                    output bg_kind, output bg_value, input ready);
    modport sink   (input valid, input action, input char_out, input bold,
                    input italic, input underline, input fg_kind, input fg_value,
                    input bg_kind, input bg_value, output ready);
endinterface
`default_nettype wire

/* rtl/aesf_sgr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aesf_sgr
// SGR parameter engine: applies one finished parameter to the working style,
// and on the final 'm' replays a truncated rgb colour as plain codes.
// ----------------------------------------------------------------------------
module aesf_sgr (
    input  var aesf_pkg::t_sgr i_state,
    input  var logic [15:0]    i_param,
    input  var logic           i_final,
    output aesf_pkg::t_sgr     o_state
);

    function automatic aesf_pkg::t_style set_col(aesf_pkg::t_style s, logic fg, logic def,
                                                 logic [1:0] kind, logic [23:0] val);
        aesf_pkg::t_style r;
        r = s;
        if (fg) begin
            r.fg_def   = def;
            r.fg_kind  = kind;
            r.fg_value = val;
        end else begin
            r.bg_def   = def;
            r.bg_kind  = kind;
            r.bg_value = val;
        end
        return r;
    endfunction

    function automatic logic [7:0] cube_level(logic [7:0] v);
        return (v == 8'd0) ? 8'd0 : 8'(v * 8'd40 + 8'd55);
    endfunction

    function automatic aesf_pkg::t_style set_indexed(aesf_pkg::t_style s, logic fg,
                                                     logic [15:0] n);
        logic [7:0]  b;
        logic [7:0]  q36;
        logic [7:0]  rem36;
        logic [7:0]  q6;
        logic [7:0]  r6;
        logic [7:0]  grey;
        aesf_pkg::t_style r;
        b     = 8'(n[7:0] - 8'd16);
        // b < 216: divide by 36 and by 6 through reciprocal multiplies
        q36   = 8'((16'(b) * 16'd57) >> 11);
        rem36 = 8'(b - 8'(q36 * 8'd36));
        q6    = 8'((16'(rem36) * 16'd43) >> 8);
        r6    = 8'(rem36 - 8'(q6 * 8'd6));
        grey  = 8'((n[7:0] - 8'd232) * 8'd10 + 8'd8);
        if (n < 16'd16) begin
            r = set_col(s, fg, 1'b0, aesf_pkg::KIND_PALETTE, 24'(n[3:0]));
        end else if (n < 16'd232) begin
            r = set_col(s, fg, 1'b0, aesf_pkg::KIND_RGB,
                        {cube_level(q36), cube_level(q6), cube_level(r6)});
        end else if (n < 16'd256) begin
            r = set_col(s, fg, 1'b0, aesf_pkg::KIND_RGB, {grey, grey, grey});
        end else begin
            r = set_col(s, fg, 1'b1, aesf_pkg::KIND_PALETTE, 24'd0);
        end
        return r;
    endfunction

    function automatic aesf_pkg::t_style apply_plain(aesf_pkg::t_style s, logic [15:0] p);
        aesf_pkg::t_style r;
        r = s;
        case (p)
            16'd0:  r = aesf_pkg::style_clear();
            16'd1:  r.bold      = 1'b1;
            16'd3:  r.italic    = 1'b1;
            16'd4:  r.underline = 1'b1;
            16'd7:  r.reverse   = 1'b1;
            16'd22: r.bold      = 1'b0;
            16'd23: r.italic    = 1'b0;
            16'd24: r.underline = 1'b0;
            16'd27: r.reverse   = 1'b0;
            16'd39: r.fg_def    = 1'b1;
            16'd49: r.bg_def    = 1'b1;
            default: begin
                if (p >= 16'd30 && p <= 16'd37)
                    r = set_col(s, 1'b1, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 16'd30));
                else if (p >= 16'd40 && p <= 16'd47)
                    r = set_col(s, 1'b0, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 16'd40));
                else if (p >= 16'd90 && p <= 16'd97)
                    r = set_col(s, 1'b1, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 16'd82));
                else if (p >= 16'd100 && p <= 16'd107)
                    r = set_col(s, 1'b0, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 16'd92));
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] clamp8(logic [15:0] p);
        return (p > 16'd255) ? 8'hff : p[7:0];
    endfunction

    function automatic aesf_pkg::t_sgr feed(aesf_pkg::t_sgr st, logic [15:0] p);
        aesf_pkg::t_sgr r;
        r = st;
        case (st.phase)
            aesf_pkg::XP_MODE: begin
                r.phase = (p == 16'd5) ? aesf_pkg::XP_INDEX :
                          (p == 16'd2) ? aesf_pkg::XP_RED : aesf_pkg::XP_NONE;
            end
            aesf_pkg::XP_INDEX: begin
                r.work  = set_indexed(st.work, st.is_fg, p);
                r.phase = aesf_pkg::XP_NONE;
            end
            aesf_pkg::XP_RED: begin
                r.red   = clamp8(p);
                r.phase = aesf_pkg::XP_GREEN;
            end
            aesf_pkg::XP_GREEN: begin
                r.green = clamp8(p);
                r.phase = aesf_pkg::XP_BLUE;
            end
            aesf_pkg::XP_BLUE: begin
                r.work  = set_col(st.work, st.is_fg, 1'b0, aesf_pkg::KIND_RGB,
                                  {st.red, st.green, clamp8(p)});
                r.phase = aesf_pkg::XP_NONE;
            end
            default: begin
                if (p == 16'd38 || p == 16'd48) begin
                    r.is_fg = (p == 16'd38);
                    r.phase = aesf_pkg::XP_MODE;
                end else begin
                    r.work = apply_plain(st.work, p);
                end
            end
        endcase
        return r;
    endfunction

    aesf_pkg::t_sgr s_first;
    aesf_pkg::t_sgr s_tail;

    assign s_first = feed(i_state, i_param);

    // A cut-short rgb colour at 'm': the parameters already taken become plain codes
    always_comb begin
        s_tail       = s_first;
        s_tail.phase = aesf_pkg::XP_NONE;
        if (s_first.phase == aesf_pkg::XP_GREEN || s_first.phase == aesf_pkg::XP_BLUE) begin
            s_tail = feed(s_tail, {8'd0, s_first.red});
        end
        if (s_first.phase == aesf_pkg::XP_BLUE) begin
            s_tail = feed(s_tail, {8'd0, s_first.green});
        end
        s_tail.phase = aesf_pkg::XP_NONE;
    end

    assign o_state = i_final ? s_tail : s_first;

endmodule
`default_nettype wire

/* rtl/ansi_escape_sgr_filter.sv */
`default_nettype none
// An accepted byte passes through the input register and then the result register.
// Throughput: one byte per clock while the result side is not stalled; parse state and style update together.
// The result register frees as its beat is taken; while a result beat waits, the held byte and the input stall.
// Reset (synchronous, active low): parser to ground, both styles default, no beats held.
// ----------------------------------------------------------------------------
// ansi_escape_sgr_filter
// Strips ESC, CSI and OSC sequences from a terminal byte stream and reports
// one display action per byte with the live character style.
// ----------------------------------------------------------------------------
module ansi_escape_sgr_filter (
    input  var logic     i_clk,
    input  var logic     i_rst_n,
    aesf_in_if.sink      i_in,
    aesf_out_if.source   o_out
);

    localparam logic [2:0] PM_GROUND  = 3'd0;
    localparam logic [2:0] PM_ESC     = 3'd1;
    localparam logic [2:0] PM_CSI     = 3'd2;
    localparam logic [2:0] PM_OSC     = 3'd3;
    localparam logic [2:0] PM_OSC_ESC = 3'd4;

    logic                r_in_valid;
    logic [7:0]          r_byte;
    logic [2:0]          r_mode,  n_mode;
    logic [15:0]         r_accum, n_accum;
    aesf_pkg::t_sgr      r_sgr,   n_sgr;
    aesf_pkg::t_style    r_live,  n_live;
    logic                r_out_valid;
    logic [2:0]          r_action, n_action;
    logic [7:0]          r_char,   n_char;
    logic                r_bold, r_italic, r_underline;
    logic [1:0]          r_fg_kind, n_fg_kind, r_bg_kind, n_bg_kind;
    logic [23:0]         r_fg_value, n_fg_value, r_bg_value, n_bg_value;

    logic                advance;
    logic                do_final;
    logic [19:0]         accum_x10;
    aesf_pkg::t_sgr      sgr_next;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign accum_x10 = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                     + {12'd0, 8'(r_byte - aesf_pkg::CH_ZERO)};

    aesf_sgr u_sgr (
        .i_state (r_sgr),
        .i_param (r_accum),
        .i_final (do_final),
        .o_state (sgr_next)
    );

    always_comb begin
        n_mode   = r_mode;
        n_accum  = r_accum;
        n_sgr    = r_sgr;
        n_live   = r_live;
        n_action = aesf_pkg::ACT_NONE;
        n_char   = 8'd0;
        do_final = 1'b0;
        case (r_mode)
            PM_ESC: begin
                if (r_byte == aesf_pkg::CH_LBRACK) begin
                    n_mode        = PM_CSI;
                    n_sgr.work    = r_live;
                    n_sgr.phase   = aesf_pkg::XP_NONE;
                    n_accum       = 16'd0;
                end else if (r_byte == aesf_pkg::CH_RBRACK) begin
                    n_mode = PM_OSC;
                end else begin
                    n_mode = PM_GROUND;
                end
            end
            PM_CSI: begin
                if (r_byte >= aesf_pkg::CH_FIN_LO && r_byte <= aesf_pkg::CH_FIN_HI) begin
                    n_mode = PM_GROUND;
                    if (r_byte == aesf_pkg::CH_M) begin
                        do_final = 1'b1;
                        n_sgr    = sgr_next;
                        n_live   = sgr_next.work;
                        n_accum  = 16'd0;
                    end
                end else if (r_byte >= aesf_pkg::CH_ZERO && r_byte <= aesf_pkg::CH_NINE) begin
                    n_accum = (accum_x10 > 20'd65535) ? 16'hffff : accum_x10[15:0];
                end else if (r_byte == aesf_pkg::CH_SEMI) begin
                    n_sgr    = sgr_next;
                    n_accum  = 16'd0;
                end
            end
            PM_OSC: begin
                if (r_byte == aesf_pkg::CH_BEL)      n_mode = PM_GROUND;
                else if (r_byte == aesf_pkg::CH_ESC) n_mode = PM_OSC_ESC;
            end
            PM_OSC_ESC: begin
                if (r_byte == aesf_pkg::CH_BSLASH || r_byte == aesf_pkg::CH_BEL)
                    n_mode = PM_GROUND;
                else if (r_byte != aesf_pkg::CH_ESC)
                    n_mode = PM_OSC;
            end
            default: begin
                n_mode = PM_GROUND;
                if (r_byte == aesf_pkg::CH_ESC) begin
                    n_mode = PM_ESC;
                end else if (r_byte == aesf_pkg::CH_CR) begin
                    n_action = aesf_pkg::ACT_CR;
                end else if (r_byte == aesf_pkg::CH_LF) begin
                    n_action = aesf_pkg::ACT_LF;
                end else if (r_byte == aesf_pkg::CH_BS) begin
                    n_action = aesf_pkg::ACT_BS;
                end else if (r_byte == aesf_pkg::CH_TAB || r_byte >= aesf_pkg::CH_SPACE) begin
                    n_action = aesf_pkg::ACT_PRINT;
                    n_char   = r_byte;
                end
            end
        endcase
    end

    // Colour presentation; reverse video swaps foreground and background
    always_comb begin
        logic [1:0]  fk;
        logic [1:0]  bk;
        logic [23:0] fv;
        logic [23:0] bv;
        fk = n_live.fg_def ? aesf_pkg::KIND_DEFAULT : n_live.fg_kind;
        fv = n_live.fg_def ? 24'd0 : n_live.fg_value;
        bk = n_live.bg_def ? aesf_pkg::KIND_NONE : n_live.bg_kind;
        bv = n_live.bg_def ? 24'd0 : n_live.bg_value;
        if (n_live.reverse) begin
            n_fg_kind  = bk;
            n_fg_value = bv;
            n_bg_kind  = fk;
            n_bg_value = fv;
        end else begin
            n_fg_kind  = fk;
            n_fg_value = fv;
            n_bg_kind  = bk;
            n_bg_value = bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= PM_GROUND;
            r_accum     <= 16'd0;
            r_sgr       <= '{work: aesf_pkg::style_clear(), phase: aesf_pkg::XP_NONE,
                             is_fg: 1'b0, red: 8'd0, green: 8'd0};
            r_live      <= aesf_pkg::style_clear();
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_accum     <= n_accum;
                r_sgr       <= n_sgr;
                r_live      <= n_live;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.byte_in;
        end
        if (advance) begin
            r_action    <= n_action;
            r_char      <= n_char;
            r_bold      <= n_live.bold;
            r_italic    <= n_live.italic;
            r_underline <= n_live.underline;
            r_fg_kind   <= n_fg_kind;
            r_fg_value  <= n_fg_value;
            r_bg_kind   <= n_bg_kind;
            r_bg_value  <= n_bg_value;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.action    = r_action;
    assign o_out.char_out  = r_char;
    assign o_out.bold      = r_bold;
    assign o_out.italic    = r_italic;
    assign o_out.underline = r_underline;
    assign o_out.fg_kind   = r_fg_kind;
    assign o_out.fg_value  = r_fg_value;
    assign o_out.bg_kind   = r_bg_kind;
    assign o_out.bg_value  = r_bg_value;

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape filter: streams raw terminal bytes with
// random gaps on both channels and checks every result beat against a
// cycle-free prediction of parser state and SGR style.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_BYTES = 1600;
    localparam int unsigned ATTR_CODES [11] = '{0, 1, 3, 4, 7, 22, 23, 24, 27, 39, 49};

    localparam logic [2:0] ST_GROUND  = 3'd0;
    localparam logic [2:0] ST_ESC     = 3'd1;
    localparam logic [2:0] ST_CSI     = 3'd2;
    localparam logic [2:0] ST_OSC     = 3'd3;
    localparam logic [2:0] ST_OSC_ESC = 3'd4;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_out;
        logic        bold;
        logic        italic;
        logic        underline;
        logic [1:0]  fg_kind;
        logic [23:0] fg_value;
        logic [1:0]  bg_kind;
        logic [23:0] bg_value;
    } t_disp_result;

    // Tracks parser and style, holds the display results still to arrive
    class style_checker;
        logic [2:0]        state;
        int unsigned       accum;
        logic [2:0]        phase;
        logic              ext_fg;
        logic [7:0]        ext_r;
        logic [7:0]        ext_g;
        aesf_pkg::t_style  live;
        aesf_pkg::t_style  work;
        t_disp_result      expected_q[$];
        int                n_bytes;
        int                n_sgr;
        int                n_bad;
        int                n_act[5];

        function new();
            state  = ST_GROUND;
            accum  = 0;
            phase  = aesf_pkg::XP_NONE;
            ext_fg = 1'b0;
            ext_r  = '0;
            ext_g  = '0;
            live   = cleared_style();
            work   = cleared_style();
        endfunction

        function aesf_pkg::t_style cleared_style();
            aesf_pkg::t_style s;
            s         = '0;
            s.fg_def  = 1'b1;
            s.bg_def  = 1'b1;
            s.fg_kind = aesf_pkg::KIND_PALETTE;
            s.bg_kind = aesf_pkg::KIND_PALETTE;
            return s;
        endfunction

        function void set_colour(bit fg, bit def, logic [1:0] kind, logic [23:0] value);
            if (fg) begin
                work.fg_def   = def;
                work.fg_kind  = kind;
                work.fg_value = value;
            end else begin
                work.bg_def   = def;
                work.bg_kind  = kind;
                work.bg_value = value;
            end
        endfunction

        function logic [7:0] cube_level(int unsigned v);
            return (v == 0) ? 8'd0 : 8'(v * 40 + 55);
        endfunction

        function void set_indexed(bit fg, int unsigned n);
            int unsigned c;
            logic [7:0]  g;
            if (n < 16) begin
                set_colour(fg, 1'b0, aesf_pkg::KIND_PALETTE, 24'(n));
            end else if (n < 232) begin
                c = n - 16;
                set_colour(fg, 1'b0, aesf_pkg::KIND_RGB,
                           {cube_level(c / 36), cube_level((c / 6) % 6), cube_level(c % 6)});
            end else if (n < 256) begin
                g = 8'((n - 232) * 10 + 8);
                set_colour(fg, 1'b0, aesf_pkg::KIND_RGB, {g, g, g});
            end else begin
                set_colour(fg, 1'b1, aesf_pkg::KIND_PALETTE, 24'd0);
            end
        endfunction

        function void apply_plain(int unsigned p);
            case (p)
                0:  work = cleared_style();
                1:  work.bold      = 1'b1;
                3:  work.italic    = 1'b1;
                4:  work.underline = 1'b1;
                7:  work.reverse   = 1'b1;
                22: work.bold      = 1'b0;
                23: work.italic    = 1'b0;
                24: work.underline = 1'b0;
                27: work.reverse   = 1'b0;
                39: work.fg_def    = 1'b1;
                49: work.bg_def    = 1'b1;
                default: begin
                    if (p >= 30 && p <= 37)
                        set_colour(1'b1, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 30));
                    else if (p >= 40 && p <= 47)
                        set_colour(1'b0, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 40));
                    else if (p >= 90 && p <= 97)
                        set_colour(1'b1, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 82));
                    else if (p >= 100 && p <= 107)
                        set_colour(1'b0, 1'b0, aesf_pkg::KIND_PALETTE, 24'(p - 92));
                end
            endcase
        endfunction

        function logic [7:0] clamp8(int unsigned p);
            return (p > 255) ? 8'hff : 8'(p);
        endfunction

        function void feed_param(int unsigned p);
            case (phase)
                aesf_pkg::XP_MODE:
                    phase = (p == 5) ? aesf_pkg::XP_INDEX :
                            ((p == 2) ? aesf_pkg::XP_RED : aesf_pkg::XP_NONE);
                aesf_pkg::XP_INDEX: begin
                    set_indexed(ext_fg, p);
                    phase = aesf_pkg::XP_NONE;
                end
                aesf_pkg::XP_RED: begin
                    ext_r = clamp8(p);
                    phase = aesf_pkg::XP_GREEN;
                end
                aesf_pkg::XP_GREEN: begin
                    ext_g = clamp8(p);
                    phase = aesf_pkg::XP_BLUE;
                end
                aesf_pkg::XP_BLUE: begin
                    set_colour(ext_fg, 1'b0, aesf_pkg::KIND_RGB, {ext_r, ext_g, clamp8(p)});
                    phase = aesf_pkg::XP_NONE;
                end
                default: begin
                    if (p == 38 || p == 48) begin
                        ext_fg = (p == 38);
                        phase  = aesf_pkg::XP_MODE;
                    end else begin
                        apply_plain(p);
                    end
                end
            endcase
        endfunction

        function void finish_param();
            feed_param(accum);
            accum = 0;
        endfunction

        function void finish_sgr();
            logic [2:0] held;
            logic [7:0] r;
            logic [7:0] g;
            finish_param();
            held  = phase;
            r     = ext_r;
            g     = ext_g;
            phase = aesf_pkg::XP_NONE;
            // cut-short 38/48;2: the channels already read go back in as plain codes
            if (held == aesf_pkg::XP_GREEN || held == aesf_pkg::XP_BLUE) begin
                feed_param(r);
                if (held == aesf_pkg::XP_BLUE)
                    feed_param(g);
            end
            phase = aesf_pkg::XP_NONE;
            live  = work;
            n_sgr++;
        endfunction

        function t_disp_result predict_byte(logic [7:0] b);
            t_disp_result res;
            logic [1:0]   k;
            logic [23:0]  v;
            res = '0;
            res.action = aesf_pkg::ACT_NONE;
            case (state)
                ST_ESC: begin
                    if (b == aesf_pkg::CH_LBRACK) begin
                        state = ST_CSI;
                        work  = live;
                        accum = 0;
                        phase = aesf_pkg::XP_NONE;
                    end else if (b == aesf_pkg::CH_RBRACK) begin
                        state = ST_OSC;
                    end else begin
                        state = ST_GROUND;
                    end
                end
                ST_CSI: begin
                    if (b >= aesf_pkg::CH_FIN_LO && b <= aesf_pkg::CH_FIN_HI) begin
                        if (b == aesf_pkg::CH_M)
                            finish_sgr();
                        state = ST_GROUND;
                    end else if (b >= aesf_pkg::CH_ZERO && b <= aesf_pkg::CH_NINE) begin
                        accum = accum * 10 + (b - aesf_pkg::CH_ZERO);
                        if (accum > 65535)
                            accum = 65535;
                    end else if (b == aesf_pkg::CH_SEMI) begin
                        finish_param();
                    end
                end
                ST_OSC: begin
                    if (b == aesf_pkg::CH_BEL)
                        state = ST_GROUND;
                    else if (b == aesf_pkg::CH_ESC)
                        state = ST_OSC_ESC;
                end
                ST_OSC_ESC: begin
                    if (b == aesf_pkg::CH_BSLASH || b == aesf_pkg::CH_BEL)
                        state = ST_GROUND;
                    else if (b != aesf_pkg::CH_ESC)
                        state = ST_OSC;
                end
                default: begin
                    state = ST_GROUND;
                    if (b == aesf_pkg::CH_ESC) begin
                        state = ST_ESC;
                    end else if (b == aesf_pkg::CH_CR) begin
                        res.action = aesf_pkg::ACT_CR;
                    end else if (b == aesf_pkg::CH_LF) begin
                        res.action = aesf_pkg::ACT_LF;
                    end else if (b == aesf_pkg::CH_BS) begin
                        res.action = aesf_pkg::ACT_BS;
                    end else if (b == aesf_pkg::CH_TAB || b >= aesf_pkg::CH_SPACE) begin
                        res.action   = aesf_pkg::ACT_PRINT;
                        res.char_out = b;
                    end
                end
            endcase

            res.bold      = live.bold;
            res.italic    = live.italic;
            res.underline = live.underline;
            res.fg_kind   = live.fg_def ? aesf_pkg::KIND_DEFAULT : live.fg_kind;
            res.fg_value  = live.fg_def ? 24'd0 : live.fg_value;
            res.bg_kind   = live.bg_def ? aesf_pkg::KIND_NONE : live.bg_kind;
            res.bg_value  = live.bg_def ? 24'd0 : live.bg_value;
            if (live.reverse) begin
                k            = res.fg_kind;
                v            = res.fg_value;
                res.fg_kind  = res.bg_kind;
                res.fg_value = res.bg_value;
                res.bg_kind  = k;
                res.bg_value = v;
            end
            return res;
        endfunction

        function void note_byte(logic [7:0] b);
            t_disp_result res;
            res = predict_byte(b);
            n_act[res.action]++;
            n_bytes++;
            expected_q.push_back(res);
        endfunction

        function void check_result(t_disp_result got);
            t_disp_result want;
            if (expected_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: result beat with nothing pending, act=%0d ch=%02h",
                             got.action, got.char_out);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("ERROR: exp act=%0d ch=%02h biu=%b%b%b fg=%0d/%06h bg=%0d/%06h",
                             want.action, want.char_out, want.bold, want.italic,
                             want.underline, want.fg_kind, want.fg_value,
                             want.bg_kind, want.bg_value);
                    $display("       got act=%0d ch=%02h biu=%b%b%b fg=%0d/%06h bg=%0d/%06h",
                             got.action, got.char_out, got.bold, got.italic,
                             got.underline, got.fg_kind, got.fg_value,
                             got.bg_kind, got.bg_value);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    aesf_in_if  in_if ();
    aesf_out_if out_if ();

    ansi_escape_sgr_filter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    style_checker style_chk = new();

    logic [7:0] tx_bytes[$];
    int         tx_count = 0;
    int         rx_count = 0;
    bit         tx_burst = 1'b0;
    bit         rx_burst = 1'b0;

    always #5 i_clk = ~i_clk;

    // worst case is a few tens of thousands of cycles; this is far beyond it
    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Byte stream generation
    // ------------------------------------------------------------------------
    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endfunction

    function automatic void push_dec(int unsigned v);
        push_str($sformatf("%0d", v));
    endfunction

    function automatic int unsigned pick_code();
        case ($urandom_range(0, 5))
            0, 1:    return ATTR_CODES[$urandom_range(0, 10)];
            2:       return 30 + $urandom_range(0, 7);
            3:       return 40 + $urandom_range(0, 7);
            4:       return 90 + $urandom_range(0, 7);
            default: return 100 + $urandom_range(0, 7);
        endcase
    endfunction

    function automatic int unsigned pick_chan();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 255;
            3:       return $urandom_range(256, 9999999);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int unsigned pick_index();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 15);
            1:       return $urandom_range(16, 231);
            2:       return $urandom_range(232, 255);
            3:       return $urandom_range(256, 9999999);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [7:0] pick_csi_junk();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h00, 8'h1f));
            1:       return 8'($urandom_range(8'h20, 8'h2f));
            2:       return 8'($urandom_range(8'h3c, 8'h3f));
            default: return 8'($urandom_range(8'h80, 8'hff));
        endcase
    endfunction

    function automatic void gen_param();
        bit fg;
        fg = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0, 1, 2: push_dec(pick_code());
            3:       push_dec($urandom_range(0, 120));
            4:       push_dec($urandom_range(65536, 9999999));
            5:       ;
            6: begin
                push_dec(fg ? 38 : 48);
                push_str(";5;");
                push_dec(pick_index());
            end
            7, 8: begin
                push_dec(fg ? 38 : 48);
                push_str(";2;");
                push_dec(pick_chan());
                tx_bytes.push_back(aesf_pkg::CH_SEMI);
                push_dec(pick_chan());
                tx_bytes.push_back(aesf_pkg::CH_SEMI);
                push_dec(pick_chan());
            end
            default: begin
                push_dec(fg ? 38 : 48);
                tx_bytes.push_back(aesf_pkg::CH_SEMI);
                push_dec($urandom_range(0, 9));
            end
        endcase
    endfunction

    function automatic int unsigned pick_tail_val();
        case ($urandom_range(0, 3))
            0, 1:    return pick_code();
            2:       return $urandom_range(0, 1) ? 38 : 48;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // extended colour cut short right before the final byte
    function automatic void gen_trunc_tail();
        push_dec($urandom_range(0, 1) ? 38 : 48);
        case ($urandom_range(0, 3))
            0: ;
            1: push_str(";5");
            2: begin
                push_str(";2;");
                push_dec(pick_tail_val());
            end
            default: begin
                push_str(";2;");
                push_dec(pick_tail_val());
                tx_bytes.push_back(aesf_pkg::CH_SEMI);
                push_dec(pick_tail_val());
            end
        endcase
    endfunction

    function automatic void gen_sgr();
        int n;
        n = $urandom_range(0, 4);
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        tx_bytes.push_back(aesf_pkg::CH_LBRACK);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                tx_bytes.push_back(aesf_pkg::CH_SEMI);
            if ($urandom_range(0, 9) == 0)
                tx_bytes.push_back(pick_csi_junk());
            gen_param();
        end
        if ($urandom_range(0, 4) == 0) begin
            if (n > 0)
                tx_bytes.push_back(aesf_pkg::CH_SEMI);
            gen_trunc_tail();
        end
        tx_bytes.push_back(aesf_pkg::CH_M);
    endfunction

    function automatic void gen_text();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: begin
                    case ($urandom_range(0, 4))
                        0:       tx_bytes.push_back(aesf_pkg::CH_CR);
                        1:       tx_bytes.push_back(aesf_pkg::CH_LF);
                        2:       tx_bytes.push_back(aesf_pkg::CH_BS);
                        3:       tx_bytes.push_back(aesf_pkg::CH_TAB);
                        default: tx_bytes.push_back(aesf_pkg::CH_BEL);
                    endcase
                end
                4:       tx_bytes.push_back(8'($urandom_range(8'h7f, 8'hff)));
                5:       tx_bytes.push_back(8'($urandom_range(8'h00, 8'h1f)));
                default: tx_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
            endcase
        end
    endfunction

    function automatic void gen_csi_other();
        logic [7:0] fin;
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        tx_bytes.push_back(aesf_pkg::CH_LBRACK);
        gen_param();
        if ($urandom_range(0, 1)) begin
            tx_bytes.push_back(aesf_pkg::CH_SEMI);
            gen_param();
        end
        fin = 8'($urandom_range(aesf_pkg::CH_FIN_LO, aesf_pkg::CH_FIN_HI));
        tx_bytes.push_back((fin == aesf_pkg::CH_M) ? aesf_pkg::CH_FIN_LO : fin);
    endfunction

    function automatic void gen_osc();
        int n;
        n = $urandom_range(0, 6);
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        tx_bytes.push_back(aesf_pkg::CH_RBRACK);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0: begin
                    tx_bytes.push_back(aesf_pkg::CH_ESC);
                    tx_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
                end
                1: begin
                    tx_bytes.push_back(aesf_pkg::CH_ESC);
                    tx_bytes.push_back(aesf_pkg::CH_ESC);
                end
                default: tx_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
            endcase
        end
        case ($urandom_range(0, 2))
            0: tx_bytes.push_back(aesf_pkg::CH_BEL);
            1: begin
                tx_bytes.push_back(aesf_pkg::CH_ESC);
                tx_bytes.push_back(aesf_pkg::CH_BSLASH);
            end
            default: begin
                tx_bytes.push_back(aesf_pkg::CH_ESC);
                tx_bytes.push_back(aesf_pkg::CH_BEL);
            end
        endcase
    endfunction

    function automatic void gen_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            tx_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.byte_in <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        style_chk.note_byte(b);
        tx_count++;
        if (tx_count % 100 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0)
            send_byte(tx_bytes.pop_front());
    endtask

    // hold the input off until every pending beat has come out
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (style_chk.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int           gap;
        t_disp_result got;
        out_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            got.action    = out_if.action;
            got.char_out  = out_if.char_out;
            got.bold      = out_if.bold;
            got.italic    = out_if.italic;
            got.underline = out_if.underline;
            got.fg_kind   = out_if.fg_kind;
            got.fg_value  = out_if.fg_value;
            got.bg_kind   = out_if.bg_kind;
            got.bg_value  = out_if.bg_value;
            style_chk.check_result(got);
            rx_count++;
            if (rx_count % 100 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        bit mid_drained;
        mid_drained   = 1'b0;
        in_if.valid   = 1'b0;
        in_if.byte_in = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, controls, swallowed ESC pair, reverse with a
        // saturating parameter, OSC ended by ESC backslash, non-SGR final
        tx_bytes = '{8'h00, 8'hff, 8'h7f, aesf_pkg::CH_TAB, aesf_pkg::CH_BEL,
                     aesf_pkg::CH_CR, aesf_pkg::CH_LF, aesf_pkg::CH_BS};
        push_str("A");
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        push_str("x");
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        push_str("[7;999999m");
        push_str("B");
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        push_str("]0");
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        tx_bytes.push_back(aesf_pkg::CH_BSLASH);
        tx_bytes.push_back(aesf_pkg::CH_ESC);
        push_str("[1H");
        push_str("C");
        send_queued();
        drain_results();

        while (tx_count < N_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gen_sgr();
                4, 5:       gen_text();
                6:          gen_csi_other();
                7:          gen_osc();
                8: begin
                    tx_bytes.push_back(aesf_pkg::CH_ESC);
                    tx_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default:    gen_noise();
            endcase
            send_queued();
            if (!mid_drained && tx_count >= N_BYTES / 2) begin
                drain_results();
                mid_drained = 1'b1;
            end
        end
        in_if.valid <= 1'b0;

        while (style_chk.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d bytes with %0d SGR commits: %0d prints, %0d LF, %0d CR, %0d BS",
                 style_chk.n_bytes, style_chk.n_sgr,
                 style_chk.n_act[aesf_pkg::ACT_PRINT], style_chk.n_act[aesf_pkg::ACT_LF],
                 style_chk.n_act[aesf_pkg::ACT_CR], style_chk.n_act[aesf_pkg::ACT_BS]);
        if (style_chk.n_bad == 0 && style_chk.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
